FILE: design/mdas_pkg.sv
// ----------------------------------------------------------------------------
// mdas_pkg
// Shared types and constants of the multi-dimensional array store.
// ----------------------------------------------------------------------------
package mdas_pkg;

    localparam int MAX_DIMS    = 4;
    localparam int STORE_DEPTH = 4096;

    localparam int NUM_EXT   = 4;   // extent registers / index fields
    localparam int DIM_LIMIT = (MAX_DIMS < NUM_EXT) ? MAX_DIMS : NUM_EXT;
    localparam int EXT_W     = 12;
    localparam int CNT_W     = 3;
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int DIM_W     = $clog2(NUM_EXT);
    localparam int ADDR_W    = $clog2(STORE_DEPTH);
    localparam int TOT_W     = ADDR_W + 1;      // holds STORE_DEPTH itself
    localparam int FACT_W    = EXT_W + 1;       // extent + 1

    typedef enum logic [1:0] {
        FN_READ  = 2'd0,
        FN_WRITE = 2'd1,
        FN_CLEAR = 2'd2,
        FN_NOP   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDIM     = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_COUNT     = 3'd3,
        ST_RANGE     = 3'd4
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_3  = 3'd4;

    typedef logic [NUM_EXT-1:0][EXT_W-1:0] t_ext_arr;

    typedef struct packed {
        t_func                    func;
        logic [CNT_W-1:0]         idx_count;
        logic [EXT_W-1:0]         idx0;
        logic [EXT_W-1:0]         idx1;
        logic [EXT_W-1:0]         idx2;
        logic [EXT_W-1:0]         idx3;
        logic signed [DATA_W-1:0] wr_data;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] rd_data;
        t_status                  status;
    } t_result;

    // dimension walk results, valid while done is high
    typedef struct packed {
        logic              done;
        logic              big;
        logic              rng;
        logic [TOT_W-1:0]  size;
        logic [ADDR_W-1:0] pos;
    } t_walk;

endpackage

FILE: design/multi_dim_array_store_top.sv
// ----------------------------------------------------------------------------
// multi_dim_array_store_top
// Store of 32-bit signed entries addressed as a row-major array of up to
// four dimensions.
// ----------------------------------------------------------------------------
// Usage:
//   Software sets dim_count and extent_0..3 through the write port
//   (i_cfg_we, i_cfg_idx, i_cfg_wdata) while the block is idle, then issues
//   a clear. An item is taken when start is high and busy is low; its
//   result is shown on o_result for one cycle with o_valid high.
//   Unused operation, not dimensioned, too many dimensions: answered in
//   the cycle after acceptance, with no walk. Write and failed checks:
//   answered once the walk is done. Read: the RAM read and the read wait
//   state follow the walk. Clear: after the walk, size entries are zeroed,
//   one entry zeroed per cycle.
//   The dimension walk does one multiply step per cycle; the single RAM
//   port sets the clear length. One item is in flight at a time; busy is
//   high from acceptance until the result cycle, and a new item may be
//   taken in the cycle its predecessor's result is shown.
//   Reset clears the configuration and control registers; the RAM holds
//   no defined contents until written or cleared. Results cannot be held off.
// ----------------------------------------------------------------------------
module multi_dim_array_store_top import mdas_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in_item             i_item,
    output logic                 o_valid,
    output t_result              o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [EXT_W-1:0]     i_cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_CLEAR,
        S_RDWAIT
    } t_state;

    t_state            r_state;
    t_in_item          r_item;
    logic              r_go;
    logic              r_valid;
    t_result           r_result;
    logic [ADDR_W-1:0] r_clr_ptr;
    logic [CNT_W-1:0]  r_dim_count;
    t_ext_arr          r_extent;

    t_ext_arr          idx_arr;
    t_walk             walk;
    logic              accept;
    logic              cnt_match;
    logic              access_ok;
    logic              clr_last;
    logic [ADDR_W-1:0] n_clr_ptr;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] mem_rdata;

    assign accept    = start && !busy;
    assign idx_arr   = {r_item.idx3, r_item.idx2, r_item.idx1, r_item.idx0};
    assign cnt_match = (r_item.idx_count == r_dim_count);
    assign access_ok = walk.done && !walk.big && !walk.rng && cnt_match &&
                       (r_item.func == FN_READ || r_item.func == FN_WRITE);
    assign clr_last  = ({1'b0, r_clr_ptr} == walk.size - TOT_W'(1));
    assign n_clr_ptr = r_clr_ptr + ADDR_W'(1);

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = walk.pos;
        mem_wdata = r_item.wr_data;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_addr  = r_clr_ptr;
            mem_wdata = '0;
        end else if (r_state == S_WALK && access_ok) begin
            mem_we = (r_item.func == FN_WRITE);
            mem_re = (r_item.func == FN_READ);
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count <= '0;
            r_extent    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DIM_COUNT: r_dim_count <= i_cfg_wdata[CNT_W-1:0];
                CFG_EXTENT_0:  r_extent[0] <= i_cfg_wdata;
                CFG_EXTENT_1:  r_extent[1] <= i_cfg_wdata;
                CFG_EXTENT_2:  r_extent[2] <= i_cfg_wdata;
                CFG_EXTENT_3:  r_extent[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_go      <= 1'b0;
            r_valid   <= 1'b0;
            r_clr_ptr <= '0;
        end else begin
            r_valid <= 1'b0;
            r_go    <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_item           <= i_item;
                        r_result.rd_data <= '0;
                        // shape checks that need no walk answer at once
                        if (i_item.func == FN_NOP) begin
                            r_valid         <= 1'b1;
                            r_result.status <= ST_OK;
                        end else if (r_dim_count == '0) begin
                            r_valid         <= 1'b1;
                            r_result.status <= ST_UNDIM;
                        end else if (r_dim_count > CNT_W'(DIM_LIMIT)) begin
                            r_valid         <= 1'b1;
                            r_result.status <= ST_TOO_LARGE;
                        end else begin
                            r_go    <= 1'b1;
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (walk.done) begin
                        priority if (walk.big) begin
                            r_valid         <= 1'b1;
                            r_result.status <= ST_TOO_LARGE;
                            r_state         <= S_IDLE;
                        end else if (r_item.func == FN_CLEAR) begin
                            r_state <= S_CLEAR;
                        end else if (!cnt_match) begin
                            r_valid         <= 1'b1;
                            r_result.status <= ST_COUNT;
                            r_state         <= S_IDLE;
                        end else if (walk.rng) begin
                            r_valid         <= 1'b1;
                            r_result.status <= ST_RANGE;
                            r_state         <= S_IDLE;
                        end else if (r_item.func == FN_WRITE) begin
                            r_valid         <= 1'b1;
                            r_result.status <= ST_OK;
                            r_state         <= S_IDLE;
                        end else begin
                            r_state <= S_RDWAIT;
                        end
                    end
                end
                S_CLEAR: begin
                    if (clr_last) begin
                        r_clr_ptr       <= '0;
                        r_valid         <= 1'b1;
                        r_result.status <= ST_OK;
                        r_state         <= S_IDLE;
                    end else begin
                        r_clr_ptr <= n_clr_ptr;
                    end
                end
                S_RDWAIT: begin
                    r_valid          <= 1'b1;
                    r_result.rd_data <= mem_rdata;
                    r_result.status  <= ST_OK;
                    r_state          <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    mdas_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (r_go),
        .i_dim_count (r_dim_count),
        .i_extent    (r_extent),
        .i_index     (idx_arr),
        .o_walk      (walk)
    );

    mdas_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // every accepted item either answers next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_valid))
        else $error("accepted item neither busy nor answered");

    // results with an error status carry zero data; only a read returns data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != ST_OK) |-> (o_result.rd_data == '0))
        else $error("nonzero data with error status");

    // RAM is written only by a checked write or by the clear sweep
    a_we_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLEAR ||
                    (r_state == S_WALK && r_item.func == FN_WRITE && access_ok)))
        else $error("unexpected RAM write");

    // clear pointer rests at zero outside a clear
    a_clr_ptr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |-> (r_clr_ptr == '0))
        else $error("clear pointer not parked");

    // a RAM read is followed in the next cycle by the read wait state
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |=> (r_state == S_RDWAIT))
        else $error("read wait state missed");

endmodule

FILE: design/mdas_ram.sv
// ----------------------------------------------------------------------------
// mdas_ram
// Single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module mdas_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/mdas_walk.sv
// ----------------------------------------------------------------------------
// mdas_walk
// Walks the dimensions one per cycle: entry count, row-major position
// and index range check.
// ----------------------------------------------------------------------------
module mdas_walk import mdas_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [CNT_W-1:0] i_dim_count,
    input  t_ext_arr         i_extent,
    input  t_ext_arr         i_index,
    output t_walk            o_walk
);

    localparam int TPROD_W = TOT_W + FACT_W;
    localparam int POS_W   = ADDR_W + FACT_W + 1;
    localparam logic [TPROD_W-1:0] DEPTH_P = TPROD_W'(STORE_DEPTH);

    logic              r_run;
    logic              r_done;
    logic [DIM_W-1:0]  r_d;
    logic [TOT_W-1:0]  r_total;
    logic [ADDR_W-1:0] r_pos;
    logic              r_big;
    logic              r_rng;

    logic [FACT_W-1:0]  factor;
    logic [TPROD_W-1:0] n_total;
    logic [POS_W-1:0]   n_pos;
    logic               last;

    assign factor  = {1'b0, i_extent[r_d]} + FACT_W'(1);
    assign n_total = TPROD_W'(r_total) * TPROD_W'(factor);
    assign n_pos   = POS_W'(r_pos) * POS_W'(factor) + POS_W'(i_index[r_d]);
    assign last    = (CNT_W'(r_d) == i_dim_count - CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else if (i_go) begin
            r_run   <= 1'b1;
            r_done  <= 1'b0;
            r_d     <= '0;
            r_total <= TOT_W'(1);
            r_pos   <= '0;
            r_big   <= 1'b0;
            r_rng   <= 1'b0;
        end else if (r_run) begin
            // truncation is harmless: position only used when in range
            r_total <= n_total[TOT_W-1:0];
            r_pos   <= n_pos[ADDR_W-1:0];
            if (n_total > DEPTH_P) begin
                r_big <= 1'b1;
            end
            if (i_index[r_d] > i_extent[r_d]) begin
                r_rng <= 1'b1;
            end
            if (last) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_d <= r_d + DIM_W'(1);
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_walk.done = r_done;
    assign o_walk.big  = r_big;
    assign o_walk.rng  = r_rng;
    assign o_walk.size = r_total;
    assign o_walk.pos  = r_pos;

endmodule
